>>> hdl/cfrt_pkg.sv
// ----------------------------------------------------------------------------
// Confirmable retransmit table: shared definitions
// Operation, result kind and status codes used by the table and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cfrt_pkg;

    localparam logic [2:0] OP_OPEN   = 3'd0;
    localparam logic [2:0] OP_SEND   = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [1:0] KIND_STATUS   = 2'd0;
    localparam logic [1:0] KIND_TRANSMIT = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RANGE   = 2'd1;
    localparam logic [1:0] CFG_MAX_RTX = 2'd2;

endpackage : cfrt_pkg

`default_nettype wire

>>> hdl/confirmable_retransmit_table_unit.sv
// ----------------------------------------------------------------------------
// Confirmable retransmit table
// Table of open confirmable transactions with exponential retransmit backoff.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         i_op, i_msg_id, i_confirmable,
//                                                i_random_value
// result    out        o_valid / i_ready         o_kind, o_out_msg_id, o_slot,
//                                                o_status, o_retry_count, o_is_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Open, send, clear and lookup scan the table one entry a cycle, stopping at a match.
// A send then goes through the send state, with a bit-serial modulo of the first wait
// when one is due. A tick walks the entries up to the last expiring one, sends each
// expiring entry through the send state, and then returns to idle.
// The sequencer waits in a result state while the output register still holds
// a result that has not been taken.
// Reset clears the valid and timer flags and loads the default registers.
`default_nettype none

module confirmable_retransmit_table_unit
    import cfrt_pkg::*;
#(
    parameter int ENTRIES   = 4,
    parameter int WAIT_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic [15:0] i_msg_id,
    input  wire logic        i_confirmable,
    input  wire logic [15:0] i_random_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_out_msg_id,
    output logic [3:0]       o_slot,
    output logic [1:0]       o_status,
    output logic [4:0]       o_retry_count,
    output logic             o_is_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_RES  = 6'b000100,
        S_SEND = 6'b001000,
        S_MOD  = 6'b010000,
        S_TICK = 6'b100000
    } t_state;

    t_state r_state;

    logic [15:0] r_cfg_timeout;
    logic [15:0] r_cfg_range;
    logic [3:0]  r_cfg_max;

    logic                 r_valid [ENTRIES];
    logic                 r_armed [ENTRIES];
    logic [15:0]          r_id    [ENTRIES];
    logic                 r_conf  [ENTRIES];
    logic [4:0]           r_retry [ENTRIES];
    logic [WAIT_BITS-1:0] r_wait  [ENTRIES];
    logic [WAIT_BITS-1:0] r_left  [ENTRIES];

    logic [2:0]         r_op;
    logic [15:0]        r_msg;
    logic               r_con;
    logic [15:0]        r_rnd;
    logic [IW-1:0]      r_idx;
    logic               r_found;
    logic [IW-1:0]      r_hit;
    logic               r_free_ok;
    logic [IW-1:0]      r_free;
    logic [ENTRIES-1:0] r_mask;
    logic [16:0]        r_rem;
    logic [3:0]         r_cnt;
    logic               r_mod_done;

    logic r_o_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_omsg;
    logic [3:0]  r_slot;
    logic [1:0]  r_status;
    logic [4:0]  r_rc;
    logic        r_last;

    logic                 out_free;
    logic                 in_acc;
    logic [16:0]          mod_try;
    logic [WAIT_BITS:0]   w_sum;
    logic [WAIT_BITS:0]   w_dbl;
    logic [WAIT_BITS-1:0] w_first;
    logic [WAIT_BITS-1:0] w_next;
    logic                 id_hit;

    assign out_free = !r_o_valid || i_ready;
    assign in_acc   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_valid       = r_o_valid;
    assign o_kind        = r_kind;
    assign o_out_msg_id  = r_omsg;
    assign o_slot        = r_slot;
    assign o_status      = r_status;
    assign o_retry_count = r_rc;
    assign o_is_last     = r_last;

    // One restoring-division step of the backoff modulo.
    assign mod_try = {r_rem[15:0], r_rnd[15]};

    assign w_sum   = (WAIT_BITS+1)'(r_cfg_timeout) + (WAIT_BITS+1)'(r_rem[15:0]);
    assign w_dbl   = {r_wait[r_idx], 1'b0};
    assign w_first = w_sum[WAIT_BITS] ? {WAIT_BITS{1'b1}} : w_sum[WAIT_BITS-1:0];
    assign w_next  = w_dbl[WAIT_BITS] ? {WAIT_BITS{1'b1}} : w_dbl[WAIT_BITS-1:0];
    assign id_hit  = r_valid[r_idx] && (r_id[r_idx] == r_msg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_timeout <= 16'd2000;
            r_cfg_range   <= 16'd1000;
            r_cfg_max     <= 4'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_cfg_timeout <= i_cfg_data;
                CFG_RANGE:   r_cfg_range   <= i_cfg_data;
                CFG_MAX_RTX: r_cfg_max     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_o_valid  <= 1'b0;
            r_mod_done <= 1'b0;
            r_mask     <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_armed[i] <= 1'b0;
            end
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op      <= i_op;
                        r_msg     <= i_msg_id;
                        r_con     <= i_confirmable;
                        r_rnd     <= i_random_value;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_mask    <= '0;
                        if (i_op == OP_TICK) begin
                            r_rnd   <= '0;
                            r_state <= S_TICK;
                            // Expiry is decided for all entries at once; the rest count down.
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (r_valid[i] && r_armed[i]) begin
                                    if (r_left[i] <= WAIT_BITS'(1)) begin
                                        r_mask[i] <= 1'b1;
                                    end else begin
                                        r_left[i] <= r_left[i] - WAIT_BITS'(1);
                                    end
                                end
                            end
                        end else if (i_op <= OP_LOOKUP) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (id_hit) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx;
                        r_state <= S_RES;
                    end else begin
                        if (!r_valid[r_idx] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_idx;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_RES;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_kind    <= KIND_STATUS;
                        r_omsg    <= r_msg;
                        r_rc      <= 5'd0;
                        r_last    <= 1'b1;
                        r_state   <= S_IDLE;
                        if (r_op == OP_OPEN) begin
                            if (r_found) begin
                                r_status <= ST_DUPLICATE;
                                r_slot   <= 4'(r_hit);
                            end else if (r_free_ok) begin
                                r_status        <= ST_OK;
                                r_slot          <= 4'(r_free);
                                r_valid[r_free] <= 1'b1;
                                r_armed[r_free] <= 1'b0;
                                r_id[r_free]    <= r_msg;
                                r_retry[r_free] <= 5'd0;
                            end else begin
                                r_status <= ST_FULL;
                                r_slot   <= 4'd0;
                            end
                        end else if (!r_found) begin
                            r_status <= ST_NOT_FOUND;
                            r_slot   <= 4'd0;
                        end else begin
                            r_status <= ST_OK;
                            r_slot   <= 4'(r_hit);
                            if (r_op == OP_CLEAR) begin
                                r_valid[r_hit] <= 1'b0;
                                r_armed[r_hit] <= 1'b0;
                            end else if (r_op == OP_SEND) begin
                                r_last        <= 1'b0;
                                r_conf[r_hit] <= r_con;
                                r_idx         <= r_hit;
                                r_state       <= S_SEND;
                            end
                        end
                    end
                end
                S_SEND: begin
                    if (r_conf[r_idx] && (r_retry[r_idx] <= 5'(r_cfg_max)) &&
                        (r_retry[r_idx] == 5'd0) && !r_mod_done) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        if (r_cfg_range == 16'd0) begin
                            r_rnd <= '0;
                        end
                        r_state <= S_MOD;
                    end else if (out_free) begin
                        r_mod_done <= 1'b0;
                        r_o_valid  <= 1'b1;
                        r_omsg     <= r_id[r_idx];
                        r_slot     <= 4'(r_idx);
                        r_status   <= ST_OK;
                        r_rc       <= r_retry[r_idx];
                        r_last     <= (r_mask == '0);
                        r_state    <= (r_op == OP_TICK) ? S_TICK : S_IDLE;
                        if (!r_conf[r_idx]) begin
                            r_kind         <= KIND_TRANSMIT;
                            r_valid[r_idx] <= 1'b0;
                            r_armed[r_idx] <= 1'b0;
                        end else if (r_retry[r_idx] > 5'(r_cfg_max)) begin
                            r_kind         <= KIND_TIMEOUT;
                            r_valid[r_idx] <= 1'b0;
                            r_armed[r_idx] <= 1'b0;
                        end else begin
                            r_kind         <= KIND_TRANSMIT;
                            r_armed[r_idx] <= 1'b1;
                            if (r_retry[r_idx] == 5'd0) begin
                                r_wait[r_idx] <= w_first;
                                r_left[r_idx] <= w_first;
                            end else begin
                                r_wait[r_idx] <= w_next;
                                r_left[r_idx] <= w_next;
                            end
                        end
                    end
                end
                S_MOD: begin
                    if (mod_try >= {1'b0, r_cfg_range}) begin
                        r_rem <= mod_try - {1'b0, r_cfg_range};
                    end else begin
                        r_rem <= mod_try;
                    end
                    r_rnd <= {r_rnd[14:0], 1'b0};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_mod_done <= 1'b1;
                        r_state    <= S_SEND;
                    end
                end
                S_TICK: begin
                    if (r_mask == '0) begin
                        r_state <= S_IDLE;
                    end else if (r_mask[r_idx]) begin
                        r_mask[r_idx]  <= 1'b0;
                        r_armed[r_idx] <= 1'b0;
                        if (r_retry[r_idx] != 5'd31) begin
                            r_retry[r_idx] <= r_retry[r_idx] + 5'd1;
                        end
                        r_state <= S_SEND;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule : confirmable_retransmit_table_unit

`default_nettype wire

>>> hdl/cfrt_checker.sv
// ----------------------------------------------------------------------------
// Confirmable retransmit table: port checker
// Watches the ports of the table for result and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrt_checker
    import cfrt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [2:0]  i_op,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_kind,
    input wire logic [15:0] o_out_msg_id,
    input wire logic [1:0]  o_status,
    input wire logic [4:0]  o_retry_count
);

    // A result transaction is held until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_msg_id) && $stable(o_kind))
        else $error("result dropped or changed while stalled");

    // Timeouts only happen after at least one retry.
    a_timeout_rc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_TIMEOUT |-> o_retry_count != 5'd0)
        else $error("timeout with zero retry count");

    // Only status results carry a non-ok status.
    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_kind == KIND_STATUS && o_retry_count == 5'd0)
        else $error("non-ok status on a transmit or timeout result");

    // A defined operation takes the input side out of ready in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_op <= OP_TICK) |=> !o_ready)
        else $error("input accepted again while an operation is in progress");

    a_no_kind3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind != 2'd3)
        else $error("undefined result kind");

endmodule : cfrt_checker

bind confirmable_retransmit_table_unit cfrt_checker u_cfrt_checker (.*);

`default_nettype wire

>>> tb/sv/confirmable_retransmit_table_unit_test.sv
// ----------------------------------------------------------------------------
// Confirmable retransmit table: self-checking testbench
// Drives open, send, clear, lookup, tick and undefined transactions with random idling,
// predicts every result from an internal model of the table and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module confirmable_retransmit_table_unit_test;
    import cfrt_pkg::*;

    localparam int ENTRIES   = 4;
    localparam int WAIT_BITS = 24;
    localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] msg_id;
        logic [3:0]  slot;
        logic [1:0]  status;
        logic [4:0]  retry_count;
        logic        is_last;
    } result_t;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] msg_id;
        logic        confirmable;
        logic [15:0] random_value;
        logic        typed;
        result_t     first_result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  in_op;
    logic [15:0] in_msg_id;
    logic        in_confirmable;
    logic [15:0] in_random_value;
    logic        res_valid;
    logic        res_ready;
    logic [1:0]  res_kind;
    logic [15:0] res_msg_id;
    logic [3:0]  res_slot;
    logic [1:0]  res_status;
    logic [4:0]  res_retry_count;
    logic        res_is_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    confirmable_retransmit_table_unit #(
        .ENTRIES  (ENTRIES),
        .WAIT_BITS(WAIT_BITS)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_op          (in_op),
        .i_msg_id      (in_msg_id),
        .i_confirmable (in_confirmable),
        .i_random_value(in_random_value),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_kind        (res_kind),
        .o_out_msg_id  (res_msg_id),
        .o_slot        (res_slot),
        .o_status      (res_status),
        .o_retry_count (res_retry_count),
        .o_is_last     (res_is_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // Shadow copy of the table and registers.
    logic [15:0]          base_wait;
    logic [15:0]          spread;
    logic [3:0]           retry_limit;
    logic                 slot_used   [ENTRIES];
    logic [15:0]          slot_id     [ENTRIES];
    logic                 slot_con    [ENTRIES];
    logic [4:0]           slot_tries  [ENTRIES];
    logic [WAIT_BITS-1:0] slot_wait   [ENTRIES];
    logic [WAIT_BITS-1:0] slot_left   [ENTRIES];
    logic                 slot_armed  [ENTRIES];

    result_t     pending_results[$];
    int unsigned error_count;
    int unsigned idle_cycles;
    logic        timed_out;
    logic        quiet_phase;
    logic        hold_results;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic result_t make_result(input logic [1:0] kind, input logic [15:0] id,
                                            input int slot, input logic [1:0] status,
                                            input logic [4:0] tries);
        result_t r;
        r.kind = kind;
        r.msg_id = id;
        r.slot = slot[3:0];
        r.status = status;
        r.retry_count = tries;
        r.is_last = 1'b0;
        return r;
    endfunction

    function automatic int find_slot(input logic [15:0] id);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_id[i] == id)
                return i;
        return -1;
    endfunction

    // Transmit or give up on one entry and queue the result it produces.
    function automatic void retransmit_step(input int i, input logic [15:0] rnd,
                                            ref result_t outs[$]);
        logic [WAIT_BITS:0] w;
        if (!slot_con[i]) begin
            outs.push_back(make_result(KIND_TRANSMIT, slot_id[i], i, ST_OK, slot_tries[i]));
            slot_used[i] = 1'b0;
            slot_armed[i] = 1'b0;
        end else if (slot_tries[i] <= {1'b0, retry_limit}) begin
            outs.push_back(make_result(KIND_TRANSMIT, slot_id[i], i, ST_OK, slot_tries[i]));
            if (slot_tries[i] == 0) begin
                w = (WAIT_BITS+1)'(base_wait);
                if (spread != 0)
                    w += (WAIT_BITS+1)'(rnd % spread);
            end else begin
                w = {slot_wait[i], 1'b0};
            end
            if (w > {1'b0, WAIT_MAX})
                w = {1'b0, WAIT_MAX};
            slot_wait[i] = w[WAIT_BITS-1:0];
            slot_left[i] = w[WAIT_BITS-1:0];
            slot_armed[i] = 1'b1;
        end else begin
            outs.push_back(make_result(KIND_TIMEOUT, slot_id[i], i, ST_OK, slot_tries[i]));
            slot_used[i] = 1'b0;
            slot_armed[i] = 1'b0;
        end
    endfunction

    function automatic void predict_table(input logic [2:0] op, input logic [15:0] id,
                                          input logic con, input logic [15:0] rnd);
        result_t outs[$];
        int i;
        if (op == OP_OPEN) begin
            i = find_slot(id);
            if (i >= 0) begin
                outs.push_back(make_result(KIND_STATUS, id, i, ST_DUPLICATE, 5'd0));
            end else begin
                i = 0;
                while (i < ENTRIES && slot_used[i])
                    i++;
                if (i >= ENTRIES) begin
                    outs.push_back(make_result(KIND_STATUS, id, 0, ST_FULL, 5'd0));
                end else begin
                    slot_used[i] = 1'b1;
                    slot_id[i] = id;
                    slot_tries[i] = '0;
                    slot_armed[i] = 1'b0;
                    outs.push_back(make_result(KIND_STATUS, id, i, ST_OK, 5'd0));
                end
            end
        end else if (op == OP_SEND || op == OP_CLEAR || op == OP_LOOKUP) begin
            i = find_slot(id);
            if (i < 0) begin
                outs.push_back(make_result(KIND_STATUS, id, 0, ST_NOT_FOUND, 5'd0));
            end else begin
                outs.push_back(make_result(KIND_STATUS, id, i, ST_OK, 5'd0));
                if (op == OP_SEND) begin
                    slot_con[i] = con;
                    retransmit_step(i, rnd, outs);
                end else if (op == OP_CLEAR) begin
                    slot_used[i] = 1'b0;
                    slot_armed[i] = 1'b0;
                end
            end
        end else if (op == OP_TICK) begin
            for (i = 0; i < ENTRIES; i++) begin
                if (!slot_used[i] || !slot_armed[i])
                    continue;
                if (slot_left[i] <= 1) begin
                    slot_left[i] = '0;
                    slot_armed[i] = 1'b0;
                    if (slot_tries[i] < 31)
                        slot_tries[i]++;
                    retransmit_step(i, 16'd0, outs);
                end else begin
                    slot_left[i]--;
                end
            end
        end
        if (outs.size() > 0)
            outs[outs.size()-1].is_last = 1'b1;
        foreach (outs[k])
            pending_results.push_back(outs[k]);
    endfunction

    // Result checker.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && res_valid && res_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d id %h",
                                          res_kind, res_msg_id));
            end else begin
                want = pending_results.pop_front();
                if (res_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", res_kind, want.kind));
                if (res_msg_id !== want.msg_id)
                    report_mismatch($sformatf("msg id %h, want %h", res_msg_id, want.msg_id));
                if (res_slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", res_slot, want.slot));
                if (res_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", res_status,
                                              want.status));
                if (res_retry_count !== want.retry_count)
                    report_mismatch($sformatf("retry count %0d, want %0d", res_retry_count,
                                              want.retry_count));
                if (res_is_last !== want.is_last)
                    report_mismatch($sformatf("last flag %0d, want %0d", res_is_last,
                                              want.is_last));
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    initial begin
        int burst;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_results) begin
                res_ready <= 1'b0;
                for (int k = 0; k < 400; k++)
                    @(negedge clk);
                hold_results = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 17);
                res_ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The valid flag is written with blocking assignments at the falling edge,
    // so that the end of one transaction and the start of the next can meet.
    task automatic send_item(input logic [2:0] op, input logic [15:0] id,
                             input logic con, input logic [15:0] rnd);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_op <= op;
        in_msg_id <= id;
        in_confirmable <= con;
        in_random_value <= rnd;
        do @(posedge clk); while (!in_ready);
        predict_table(op, id, con, rnd);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        // A tick may still be finishing after its last result has been taken.
        repeat (40) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_TIMEOUT: base_wait = value;
            CFG_RANGE:   spread = value;
            CFG_MAX_RTX: retry_limit = value[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // The typed rows give one result each, so it is the newest one queued.
    task automatic check_typed(input result_t want);
        result_t got;
        got = pending_results[pending_results.size()-1];
        if (got !== want)
            report_mismatch($sformatf("predicted %h differs from typed %h", got, want));
    endtask

    function automatic logic [15:0] pick_id(input logic [15:0] ids[4]);
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom());
        return ids[$urandom_range(0, 3)];
    endfunction

    // Random traffic: a weighted mix of open, send, clear, lookup, tick and undefined operations.
    task automatic random_phase(input int count, input logic [15:0] ids[4]);
        logic [2:0] op;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)      op = OP_OPEN;
            else if (pick < 40) op = OP_SEND;
            else if (pick < 48) op = OP_CLEAR;
            else if (pick < 55) op = OP_LOOKUP;
            else if (pick < 97) op = OP_TICK;
            else                op = 3'($urandom_range(5, 7));
            send_item(op, pick_id(ids), $urandom_range(0, 3) != 0, 16'($urandom()));
        end
    endtask

    stim_row_t directed[$];

    initial begin
        logic [15:0] ids[4];
        stim_row_t row;
        error_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        quiet_phase = 1'b0;
        hold_results = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_op = OP_TICK;
        in_msg_id = '0;
        in_confirmable = 1'b0;
        in_random_value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        base_wait = 16'd2000;
        spread = 16'd1000;
        retry_limit = 4'd4;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_armed[i] = 1'b0;
            slot_id[i] = '0;
            slot_con[i] = 1'b0;
            slot_tries[i] = '0;
            slot_wait[i] = '0;
            slot_left[i] = '0;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short waits so ticks expire quickly; limit 1 shows a timeout.
        write_register(CFG_TIMEOUT, 16'd0);
        write_register(CFG_RANGE, 16'd0);
        write_register(CFG_MAX_RTX, 16'd1);

        // op, id, confirmable, random, typed, expected first result
        directed = '{
            '{OP_LOOKUP, 16'h0000, 0, 0, 1, '{KIND_STATUS, 16'h0000, 0, ST_NOT_FOUND, 0, 1}},
            '{OP_OPEN,   16'hFFFF, 0, 0, 1, '{KIND_STATUS, 16'hFFFF, 0, ST_OK, 0, 1}},
            '{OP_OPEN,   16'hFFFF, 0, 0, 1, '{KIND_STATUS, 16'hFFFF, 0, ST_DUPLICATE, 0, 1}},
            '{OP_OPEN,   16'h0000, 0, 0, 1, '{KIND_STATUS, 16'h0000, 1, ST_OK, 0, 1}},
            '{OP_OPEN,   16'hAAAA, 0, 0, 1, '{KIND_STATUS, 16'hAAAA, 2, ST_OK, 0, 1}},
            '{OP_OPEN,   16'h5555, 0, 0, 1, '{KIND_STATUS, 16'h5555, 3, ST_OK, 0, 1}},
            '{OP_OPEN,   16'h1234, 0, 0, 1, '{KIND_STATUS, 16'h1234, 0, ST_FULL, 0, 1}},
            '{OP_LOOKUP, 16'hAAAA, 0, 0, 0, '{default: '0}},
            '{OP_SEND,   16'hFFFF, 1, 16'hFFFF, 0, '{default: '0}},
            '{OP_SEND,   16'h0000, 0, 16'h0000, 0, '{default: '0}},
            '{OP_SEND,   16'h5555, 1, 16'h5A5A, 0, '{default: '0}},
            '{OP_TICK,   16'h0000, 0, 0, 0, '{default: '0}},
            '{OP_TICK,   16'h0000, 0, 0, 0, '{default: '0}},
            '{OP_TICK,   16'h0000, 0, 0, 0, '{default: '0}},
            '{OP_TICK,   16'h0000, 0, 0, 0, '{default: '0}},
            '{OP_CLEAR,  16'hAAAA, 0, 0, 0, '{default: '0}},
            '{OP_CLEAR,  16'hAAAA, 0, 0, 1, '{KIND_STATUS, 16'hAAAA, 0, ST_NOT_FOUND, 0, 1}},
            '{3'd5,      16'h1111, 1, 16'h1111, 0, '{default: '0}},
            '{3'd7,      16'hFFFF, 1, 16'hFFFF, 0, '{default: '0}},
            '{OP_SEND,   16'h7777, 1, 0, 1, '{KIND_STATUS, 16'h7777, 0, ST_NOT_FOUND, 0, 1}}
        };
        foreach (directed[k]) begin
            row = directed[k];
            send_item(row.op, row.msg_id, row.confirmable, row.random_value);
            if (row.typed)
                check_typed(row.first_result);
        end
        wait_drained();

        // Wait saturation: widest base and spread, highest limit.
        write_register(CFG_TIMEOUT, 16'hFFFF);
        write_register(CFG_RANGE, 16'hFFFF);
        write_register(CFG_MAX_RTX, 16'd15);
        ids = '{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFE};
        random_phase(60, ids);
        wait_drained();

        // Sender runs on while the receiver holds results back.
        write_register(CFG_TIMEOUT, 16'd1);
        write_register(CFG_RANGE, 16'd3);
        write_register(CFG_MAX_RTX, 16'd0);
        hold_results = 1'b1;
        ids = '{16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00};
        random_phase(80, ids);
        wait_drained();

        write_register(CFG_TIMEOUT, 16'd2);
        write_register(CFG_RANGE, 16'd1);
        write_register(CFG_MAX_RTX, 16'd3);
        for (int p = 0; p < 3; p++) begin
            ids = '{16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
            random_phase(80, ids);
        end
        wait_drained();

        write_register(CFG_TIMEOUT, 16'd3);
        write_register(CFG_RANGE, 16'd5);
        write_register(CFG_MAX_RTX, 16'd2);
        quiet_phase = 1'b1;
        ids = '{16'h1357, 16'h2468, 16'hFFFF, 16'h0000};
        random_phase(80, ids);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/cfrt_pkg.sv
hdl/confirmable_retransmit_table_unit.sv
hdl/cfrt_checker.sv
tb/sv/confirmable_retransmit_table_unit_test.sv
